// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the slip frame decoder: byte codes, decode
// modes, result kinds and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0] FRAME_END     = 8'hC0;
	localparam logic [7:0] FRAME_ESC     = 8'hDB;
	localparam logic [7:0] ESC_GIVES_END = 8'hDC;
	localparam logic [7:0] ESC_GIVES_ESC = 8'hDD;

	localparam int          CFG_W           = 13;
	localparam int          LEN_OUT_W       = 13;
	localparam logic [12:0] DEFAULT_MAX_LEN = 13'd256;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_ESCAPE  = 2'd1,
		MODE_GARBAGE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data_byte;
		logic [LEN_OUT_W-1:0]   frame_length;
	} result_t;

endpackage

// ===== rtl/sfd_step.sv =====
// ----------------------------------------------------------------------------
// sfd_step
// One decode step: from the current mode, frame count and limit, works out
// the next mode and count and whether one byte gives a result.
// ----------------------------------------------------------------------------
module sfd_step #(
	parameter int LENGTH_BITS = 13
) (
	input  sfd_pkg::mode_t          mode,
	input  logic [LENGTH_BITS-1:0]  count,
	input  logic [LENGTH_BITS-1:0]  limit,
	input  logic [7:0]              rx_byte,
	output sfd_pkg::mode_t          mode_next,
	output logic [LENGTH_BITS-1:0]  count_next,
	output logic                    has_result,
	output sfd_pkg::result_t        res
);

	localparam int EXT_W = (LENGTH_BITS > sfd_pkg::LEN_OUT_W) ? LENGTH_BITS : sfd_pkg::LEN_OUT_W;

	logic             take_byte;
	logic [7:0]       dec_byte;
	logic [EXT_W-1:0] count_ext;

	assign count_ext = EXT_W'(count);

	always_comb begin
		mode_next  = sfd_pkg::MODE_NORMAL;
		take_byte  = 1'b0;
		dec_byte   = rx_byte;
		count_next = count;
		has_result = 1'b0;
		res.kind         = sfd_pkg::KIND_DATA;
		res.data_byte    = 8'd0;
		res.frame_length = '0;

		unique case (mode)
			sfd_pkg::MODE_GARBAGE: begin
				mode_next = (rx_byte == sfd_pkg::FRAME_END) ? sfd_pkg::MODE_NORMAL
					: sfd_pkg::MODE_GARBAGE;
			end
			sfd_pkg::MODE_ESCAPE: begin
				priority if (rx_byte == sfd_pkg::ESC_GIVES_END) begin
					dec_byte  = sfd_pkg::FRAME_END;
					take_byte = 1'b1;
				end else if (rx_byte == sfd_pkg::ESC_GIVES_ESC) begin
					dec_byte  = sfd_pkg::FRAME_ESC;
					take_byte = 1'b1;
				end else begin
					mode_next = sfd_pkg::MODE_GARBAGE;
				end
			end
			default: begin
				priority if (rx_byte == sfd_pkg::FRAME_ESC) begin
					mode_next = sfd_pkg::MODE_ESCAPE;
				end else if (rx_byte == sfd_pkg::FRAME_END) begin
					if (count != '0) begin
						has_result       = 1'b1;
						res.kind         = sfd_pkg::KIND_END;
						res.frame_length = count_ext[sfd_pkg::LEN_OUT_W-1:0];
						count_next       = '0;
					end
				end else begin
					take_byte = 1'b1;
				end
			end
		endcase

		if (take_byte) begin
			has_result = 1'b1;
			if (count >= limit) begin
				res.kind   = sfd_pkg::KIND_DROP;
				count_next = '0;
			end else begin
				res.data_byte = dec_byte;
				count_next    = count + LENGTH_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/slip_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Path: an accepted byte passes the input register, the combinational decode
// step and the result register; ESC bytes, broken escapes, garbage-mode bytes
// and an END with no open frame give none. Throughput: one byte per cycle
// unless a waiting result is stalled; the result register lets the input take
// a byte while a result waits. Reset: normal mode, no frame open, limit 256.
// ----------------------------------------------------------------------------
module slip_frame_decoder #(
	parameter int LENGTH_BITS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [12:0] frame_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] max_frame_length
);

	localparam int EXT_W = (LENGTH_BITS > sfd_pkg::CFG_W) ? LENGTH_BITS : sfd_pkg::CFG_W;
	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

	function automatic logic [LENGTH_BITS-1:0] sat_limit(input logic [12:0] v);
		logic [EXT_W-1:0] v_ext;
		v_ext = EXT_W'(v);
		if (v_ext > EXT_W'(COUNT_MAX))
			return COUNT_MAX;
		else
			return v_ext[LENGTH_BITS-1:0];
	endfunction

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    advance;
	sfd_pkg::mode_t          mode_q;
	logic [LENGTH_BITS-1:0]  count_q;
	logic [LENGTH_BITS-1:0]  limit_q;
	sfd_pkg::mode_t          mode_next;
	logic [LENGTH_BITS-1:0]  count_next;
	logic                    has_result;
	sfd_pkg::result_t        res;
	logic                    out_valid_q;
	sfd_pkg::result_t        res_q;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	sfd_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.mode       (mode_q),
		.count      (count_q),
		.limit      (limit_q),
		.rx_byte    (byte_s1),
		.mode_next  (mode_next),
		.count_next (count_next),
		.has_result (has_result),
		.res        (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// decode state and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sfd_pkg::MODE_NORMAL;
			count_q <= '0;
			limit_q <= sat_limit(sfd_pkg::DEFAULT_MAX_LEN);
		end else begin
			if (advance) begin
				mode_q  <= mode_next;
				count_q <= count_next;
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= sat_limit(max_frame_length);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = 2'(res_q.kind);
	assign data_byte    = res_q.data_byte;
	assign frame_length = res_q.frame_length;

	a_end_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == 2'(sfd_pkg::KIND_END) |-> frame_length != 13'd0)
		else $error("frame end with zero length");

	a_drop_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == 2'(sfd_pkg::KIND_DROP) |-> data_byte == 8'd0 && frame_length == 13'd0)
		else $error("drop marker carries payload");

	a_garbage_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == sfd_pkg::MODE_GARBAGE |=> !out_valid)
		else $error("result from garbage mode");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result && res.kind != sfd_pkg::KIND_DATA |=> count_q == '0)
		else $error("frame count not cleared");

endmodule

// ===== tb/slip_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// slip_frame_decoder_tb
// Self-checking testbench for the SLIP receive decoder. A short table of
// directed bytes covers the escape pairs, broken escapes, garbage resync,
// empty END, frame end and overflow drops at the limit extremes. Random
// SLIP-encoded frames mixed with line noise follow under several limits.
// Every result is compared with its table row or a bit-accurate decode
// predictor, with random input gaps and random stalls on the result output.
// ----------------------------------------------------------------------------
module slip_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit                 is_cfg;
		logic [12:0]        value;
		bit                 typed;
		bit                 has_res;
		sfd_pkg::result_t   res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [12:0] frame_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] max_frame_length;

	// decode state of the predictor
	sfd_pkg::mode_t rx_mode;
	logic [12:0]    frame_bytes;
	logic [12:0]    frame_limit;

	sfd_pkg::result_t pending_results[$];
	stim_row_t        stim_table[$];

	int  errors;
	int  bytes_sent;
	int  results_seen;
	int  frames_closed;
	int  frames_dropped;
	int  limits_used;
	bit  tx_quiet;
	bit  rx_quiet;

	slip_frame_decoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.data_byte        (data_byte),
		.frame_length     (frame_length),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.max_frame_length (max_frame_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic bit decode_byte(input logic [7:0] b, output sfd_pkg::result_t r);
		logic [7:0] c;
		c = b;
		r = '0;
		case (rx_mode)
			sfd_pkg::MODE_GARBAGE: begin
				if (c == sfd_pkg::FRAME_END)
					rx_mode = sfd_pkg::MODE_NORMAL;
				return 1'b0;
			end
			sfd_pkg::MODE_ESCAPE: begin
				if (c == sfd_pkg::ESC_GIVES_END)
					c = sfd_pkg::FRAME_END;
				else if (c == sfd_pkg::ESC_GIVES_ESC)
					c = sfd_pkg::FRAME_ESC;
				else begin
					rx_mode = sfd_pkg::MODE_GARBAGE;
					return 1'b0;
				end
				rx_mode = sfd_pkg::MODE_NORMAL;
			end
			default: begin
				rx_mode = sfd_pkg::MODE_NORMAL;
				if (c == sfd_pkg::FRAME_ESC) begin
					rx_mode = sfd_pkg::MODE_ESCAPE;
					return 1'b0;
				end
				if (c == sfd_pkg::FRAME_END) begin
					if (frame_bytes == '0)
						return 1'b0;
					r.kind         = sfd_pkg::KIND_END;
					r.frame_length = frame_bytes;
					frame_bytes    = '0;
					return 1'b1;
				end
			end
		endcase
		if (frame_bytes >= frame_limit) begin
			frame_bytes = '0;
			r.kind      = sfd_pkg::KIND_DROP;
			return 1'b1;
		end
		frame_bytes = frame_bytes + 13'd1;
		r.kind      = sfd_pkg::KIND_DATA;
		r.data_byte = c;
		return 1'b1;
	endfunction

	task automatic row_typed(input logic [7:0] b, input bit has, input sfd_pkg::kind_t k,
			input logic [7:0] d, input logic [12:0] len);
		stim_row_t r;
		r.is_cfg             = 1'b0;
		r.value              = {5'd0, b};
		r.typed              = 1'b1;
		r.has_res            = has;
		r.res.kind           = k;
		r.res.data_byte      = d;
		r.res.frame_length   = len;
		stim_table.push_back(r);
	endtask

	task automatic row_byte(input logic [7:0] b);
		stim_row_t r;
		r.is_cfg  = 1'b0;
		r.value   = {5'd0, b};
		r.typed   = 1'b0;
		r.has_res = 1'b0;
		r.res     = '0;
		stim_table.push_back(r);
	endtask

	task automatic row_cfg(input logic [12:0] v);
		stim_row_t r;
		r.is_cfg  = 1'b1;
		r.value   = v;
		r.typed   = 1'b0;
		r.has_res = 1'b0;
		r.res     = '0;
		stim_table.push_back(r);
	endtask

	// called just after a falling edge, returns just after one
	task automatic send_byte(input logic [7:0] b, input bit typed, input bit has_t,
			input sfd_pkg::result_t exp_t);
		int               gap;
		bit               has;
		sfd_pkg::result_t r;
		gap = tx_quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		has = decode_byte(b, r);
		if (typed) begin
			has = has_t;
			r   = exp_t;
		end
		if (has)
			pending_results.push_back(r);
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_raw(input logic [7:0] b);
		send_byte(b, 1'b0, 1'b0, '0);
	endtask

	// only once the decoder has drained
	task automatic write_limit(input logic [12:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid        <= 1'b1;
		max_frame_length <= v;
		do @(posedge clk); while (!cfg_ready);
		frame_limit = v;
		limits_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input int n);
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0:       p = sfd_pkg::FRAME_END;
					1:       p = sfd_pkg::FRAME_ESC;
					2:       p = 8'h00;
					default: p = 8'hFF;
				endcase
			end else
				p = 8'($urandom_range(0, 255));
			if (p == sfd_pkg::FRAME_END) begin
				send_raw(sfd_pkg::FRAME_ESC);
				send_raw(sfd_pkg::ESC_GIVES_END);
			end else if (p == sfd_pkg::FRAME_ESC) begin
				send_raw(sfd_pkg::FRAME_ESC);
				send_raw(sfd_pkg::ESC_GIVES_ESC);
			end else
				send_raw(p);
		end
		send_raw(sfd_pkg::FRAME_END);
	endtask

	// result side: stall, take a transfer, compare
	initial begin
		sfd_pkg::result_t want;
		int               n;
		out_stall = 1'b0;
		rx_quiet  = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_quiet = ~rx_quiet;
			n = rx_quiet ? 0 : $urandom_range(0, 8);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_seen++;
			if (kind == sfd_pkg::KIND_END)
				frames_closed++;
			if (kind == sfd_pkg::KIND_DROP)
				frames_dropped++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d data %02h len %0d",
						kind, data_byte, frame_length);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind || data_byte !== want.data_byte ||
						frame_length !== want.frame_length) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: expected kind %0d data %02h len %0d, ",
							"got kind %0d data %02h len %0d"},
							want.kind, want.data_byte, want.frame_length,
							kind, data_byte, frame_length);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		int          target;
		int          lim;
		int          n;
		logic [12:0] phase_lim;

		arst_n           = 1'b0;
		in_valid         = 1'b0;
		rx_byte          = 8'h00;
		cfg_valid        = 1'b0;
		max_frame_length = 13'd0;
		tx_quiet         = 1'b0;
		errors           = 0;
		bytes_sent       = 0;
		results_seen     = 0;
		frames_closed    = 0;
		frames_dropped   = 0;
		limits_used      = 0;
		rx_mode          = sfd_pkg::MODE_NORMAL;
		frame_bytes      = '0;
		frame_limit      = sfd_pkg::DEFAULT_MAX_LEN;

		// directed table, starting from the reset limit
		row_typed(sfd_pkg::FRAME_END, 1'b0, sfd_pkg::KIND_DATA, 8'h00, 13'd0);
		row_typed(8'h00, 1'b1, sfd_pkg::KIND_DATA, 8'h00, 13'd0);
		row_typed(8'hFF, 1'b1, sfd_pkg::KIND_DATA, 8'hFF, 13'd0);
		row_byte(sfd_pkg::FRAME_ESC);
		row_typed(sfd_pkg::ESC_GIVES_END, 1'b1, sfd_pkg::KIND_DATA, sfd_pkg::FRAME_END,
			13'd0);
		row_byte(sfd_pkg::FRAME_ESC);
		row_typed(sfd_pkg::ESC_GIVES_ESC, 1'b1, sfd_pkg::KIND_DATA, sfd_pkg::FRAME_ESC,
			13'd0);
		row_typed(sfd_pkg::FRAME_END, 1'b1, sfd_pkg::KIND_END, 8'h00, 13'd4);
		row_byte(8'h55);
		row_byte(sfd_pkg::FRAME_ESC);
		row_byte(8'h7E);
		row_byte(8'h66);
		row_byte(sfd_pkg::FRAME_END);
		row_byte(8'h77);
		row_byte(sfd_pkg::FRAME_END);
		row_cfg(13'd1);
		row_typed(8'h11, 1'b1, sfd_pkg::KIND_DATA, 8'h11, 13'd0);
		row_typed(8'h22, 1'b1, sfd_pkg::KIND_DROP, 8'h00, 13'd0);
		row_typed(8'h33, 1'b1, sfd_pkg::KIND_DATA, 8'h33, 13'd0);
		row_typed(sfd_pkg::FRAME_END, 1'b1, sfd_pkg::KIND_END, 8'h00, 13'd1);
		row_cfg(13'd0);
		row_typed(8'h44, 1'b1, sfd_pkg::KIND_DROP, 8'h00, 13'd0);
		row_byte(sfd_pkg::FRAME_ESC);
		row_typed(sfd_pkg::ESC_GIVES_END, 1'b1, sfd_pkg::KIND_DROP, 8'h00, 13'd0);
		row_typed(sfd_pkg::FRAME_END, 1'b0, sfd_pkg::KIND_DATA, 8'h00, 13'd0);
		row_cfg(13'h1FFF);
		row_byte(8'hA5);
		row_byte(sfd_pkg::FRAME_END);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			tx_quiet = (i % 8) >= 5;
			if (stim_table[i].is_cfg)
				write_limit(stim_table[i].value);
			else
				send_byte(stim_table[i].value[7:0], stim_table[i].typed,
					stim_table[i].has_res, stim_table[i].res);
		end

		// random frames and line noise under a spread of limits
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0:       phase_lim = sfd_pkg::DEFAULT_MAX_LEN;
				1:       phase_lim = 13'd1;
				2:       phase_lim = 13'd0;
				3:       phase_lim = 13'd4096;
				4:       phase_lim = 13'h1FFF;
				5:       phase_lim = 13'($urandom_range(2, 40));
				default: phase_lim = 13'($urandom_range(1, 8191));
			endcase
			write_limit(phase_lim);
			lim    = int'(phase_lim);
			target = bytes_sent + 100;
			while (bytes_sent < target) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 3))
						0: send_raw(8'($urandom_range(0, 255)));
						1: begin
							send_raw(sfd_pkg::FRAME_ESC);
							send_raw(8'($urandom_range(0, 255)));
						end
						2: send_raw(sfd_pkg::FRAME_END);
						default: repeat ($urandom_range(1, 6))
							send_raw(8'($urandom_range(0, 255)));
					endcase
				end else begin
					if (lim <= 48 && $urandom_range(0, 2) == 0)
						n = $urandom_range(lim, lim + 2);
					else
						n = $urandom_range(0, 16);
					send_frame(n);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("sent %0d bytes under %0d limit settings", bytes_sent, limits_used);
		$display("checked %0d results: %0d frames closed, %0d dropped, %0d errors",
			results_seen, frames_closed, frames_dropped, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
